// ===== rtl/lfr_pkg.sv =====
package lfr_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_DATA_BYTES = 2'd0;
  localparam logic [1:0] REG_WATCH_ID   = 2'd1;
  localparam logic [1:0] REG_ENHANCED   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [3:0] DATA_BYTES_RST = 4'd8;
  localparam logic [5:0] WATCH_ID_RST   = 6'h30;
  localparam logic       ENHANCED_RST   = 1'b1;

  // Largest data field; longer settings saturate to it.
  localparam logic [3:0] MAX_DATA_BYTES = 4'd8;

  // Input command codes.
  localparam logic CMD_BREAK = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_CSUM   = 2'd1;
  localparam logic [1:0] ST_PARITY = 2'd2;

  // Identifier field of the protected identifier.
  localparam logic [7:0] ID_MASK = 8'h3F;

  typedef struct packed {
    logic [3:0] data_bytes;
    logic [5:0] watch_id;
    logic       enhanced;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic [5:0] frame_id;
    logic       target_hit;
    logic [7:0] computed_checksum;
    logic       led_on;
  } res_t;

endpackage

// ===== rtl/lfr_in_stage.sv =====
module lfr_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       item_valid,
  output logic       item_command,
  output logic [7:0] item_byte
);

  logic       valid_r;
  logic       command_r;
  logic [7:0] byte_r;

  // The register takes a new transfer when empty or when its item moves on.
  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      command_r <= in_command;
      byte_r    <= in_rx_byte;
    end
  end

  assign item_valid   = valid_r;
  assign item_command = command_r;
  assign item_byte    = byte_r;

endmodule

// ===== rtl/lfr_deframer.sv =====
module lfr_deframer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          command,
  input  logic [7:0]    rx_byte,
  input  lfr_pkg::cfg_t cfg,
  output lfr_pkg::res_t res
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SYNC = 2'd1;
  localparam logic [1:0] PH_PID  = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] pid_r, pid_nxt;
  logic [3:0] count_r, count_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       led_r, led_nxt;

  logic [3:0] len;
  logic [8:0] raw_sum;
  logic [7:0] carry_sum;
  logic       p0;
  logic       p1;
  logic       pid_good;
  logic [7:0] csum;
  logic [5:0] frame_id;
  logic       csum_good;
  logic       hit;

  // Data length saturates at the largest frame.
  assign len = (cfg.data_bytes > lfr_pkg::MAX_DATA_BYTES) ?
               lfr_pkg::MAX_DATA_BYTES : cfg.data_bytes;

  // End-around-carry addition of the received byte.
  assign raw_sum   = {1'b0, sum_r} + {1'b0, rx_byte};
  assign carry_sum = raw_sum[7:0] + {7'd0, raw_sum[8]};

  // PID parity bits as computed from the identifier.
  assign p0       = rx_byte[0] ^ rx_byte[1] ^ rx_byte[2] ^ rx_byte[4];
  assign p1       = ~(rx_byte[1] ^ rx_byte[3] ^ rx_byte[4] ^ rx_byte[5]);
  assign pid_good = (rx_byte[6] == p0) && (rx_byte[7] == p1);

  // Checksum compare at the end of the frame.
  assign csum      = ~sum_r;
  assign frame_id  = pid_r[5:0];
  assign csum_good = (csum == rx_byte);
  assign hit       = csum_good && (frame_id == cfg.watch_id);

  always_comb begin
    phase_nxt = phase_r;
    pid_nxt   = pid_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    led_nxt   = led_r;
    res       = '0;
    if (command == lfr_pkg::CMD_BREAK) begin
      // A break restarts the frame from any phase.
      phase_nxt = PH_SYNC;
      pid_nxt   = 8'd0;
      count_nxt = 4'd0;
      sum_nxt   = 8'd0;
    end else begin
      case (phase_r)
        PH_SYNC: begin
          phase_nxt = PH_PID;
        end
        PH_PID: begin
          pid_nxt = rx_byte;
          if (!pid_good) begin
            phase_nxt            = PH_IDLE;
            res.valid            = 1'b1;
            res.status           = lfr_pkg::ST_PARITY;
            res.frame_id         = rx_byte[5:0];
            res.target_hit       = 1'b0;
            res.computed_checksum = 8'd0;
            res.led_on           = led_r;
          end else begin
            phase_nxt = PH_DATA;
            count_nxt = 4'd0;
            sum_nxt   = cfg.enhanced ? rx_byte : 8'd0;
          end
        end
        PH_DATA: begin
          if (count_r < len) begin
            sum_nxt   = carry_sum;
            count_nxt = count_r + 4'd1;
          end else begin
            // Checksum byte closes the frame.
            phase_nxt             = PH_IDLE;
            led_nxt               = led_r ^ hit;
            res.valid             = 1'b1;
            res.status            = csum_good ? lfr_pkg::ST_OK : lfr_pkg::ST_CSUM;
            res.frame_id          = frame_id;
            res.target_hit        = hit;
            res.computed_checksum = csum;
            res.led_on            = led_r ^ hit;
          end
        end
        default: begin
          // Bytes outside a frame are dropped.
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pid_r   <= 8'd0;
      count_r <= 4'd0;
      sum_r   <= 8'd0;
      led_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pid_r   <= pid_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      led_r   <= led_nxt;
    end
  end

endmodule

// ===== rtl/lin_frame_receiver.sv =====
// LIN responder frame receiver. Each input transfer is either a break
// (in_command 0) or one received UART byte (in_command 1). A break starts a
// new frame; the next byte is the sync byte, then the PID, whose parity is
// checked, then the configured number of data bytes and the checksum byte.
// One result transfer is given on a PID parity error and at the end of each
// frame; all other items give none. The block takes one item per clock
// cycle while out_ready does not hold a result: the item passes an input
// register, is decoded against the frame state combinationally, and its
// result lands in an output register once that register is free or emptied.
// While a result waits on out_ready, one more item can wait in the input
// register, after which in_ready stays low. Configuration writes are always
// ready and must be made only while no frame is in flight.
module lin_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [5:0] out_frame_id,
  output logic       out_target_hit,
  output logic [7:0] out_computed_checksum,
  output logic       out_led_on,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data
);

  lfr_pkg::cfg_t cfg_r;
  lfr_pkg::res_t res;
  lfr_pkg::res_t out_r;

  logic       item_valid;
  logic       item_command;
  logic [7:0] item_byte;
  logic       step;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_bytes <= lfr_pkg::DATA_BYTES_RST;
      cfg_r.watch_id   <= lfr_pkg::WATCH_ID_RST;
      cfg_r.enhanced   <= lfr_pkg::ENHANCED_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lfr_pkg::REG_DATA_BYTES: cfg_r.data_bytes <= cfg_data[3:0];
        lfr_pkg::REG_WATCH_ID:   cfg_r.watch_id   <= cfg_data;
        lfr_pkg::REG_ENHANCED:   cfg_r.enhanced   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // An item is processed when the output register is free or being emptied.
  assign step = item_valid && (!out_r.valid || out_ready);

  lfr_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_rx_byte   (in_rx_byte),
    .advance      (step),
    .item_valid   (item_valid),
    .item_command (item_command),
    .item_byte    (item_byte)
  );

  lfr_deframer u_deframer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .command (item_command),
    .rx_byte (item_byte),
    .cfg     (cfg_r),
    .res     (res)
  );

  // Output register holds a result until its transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (!out_r.valid || out_ready) begin
      out_r.valid <= res.valid;
    end
    if (res.valid) begin
      out_r.status            <= res.status;
      out_r.frame_id          <= res.frame_id;
      out_r.target_hit        <= res.target_hit;
      out_r.computed_checksum <= res.computed_checksum;
      out_r.led_on            <= res.led_on;
    end
  end

  assign out_valid             = out_r.valid;
  assign out_status            = out_r.status;
  assign out_frame_id          = out_r.frame_id;
  assign out_target_hit        = out_r.target_hit;
  assign out_computed_checksum = out_r.computed_checksum;
  assign out_led_on            = out_r.led_on;

endmodule

// ===== verif/lin_frame_receiver_tb.sv =====
`timescale 1ns / 1ps

// Frame-level predictor and result checker for the LIN frame receiver.
class lin_scoreboard;
  typedef enum logic [1:0] {WAIT_IDLE, WAIT_SYNC, WAIT_PID, IN_DATA} rx_phase_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] frame_id;
    logic       target_hit;
    logic [7:0] checksum;
    logic       led_on;
  } frame_result_t;

  // Register copy.
  logic [3:0] data_bytes;
  logic [5:0] watch_id;
  logic       enhanced;

  // Deframer state.
  rx_phase_t  phase;
  logic [7:0] frame_pid;
  logic [3:0] byte_count;
  logic [7:0] running_sum;
  logic       indicator;

  frame_result_t result_q[$];
  int errors;
  int ok_frames;
  int target_hits;
  int csum_errs;
  int parity_errs;

  function new();
    data_bytes  = lfr_pkg::DATA_BYTES_RST;
    watch_id    = lfr_pkg::WATCH_ID_RST;
    enhanced    = lfr_pkg::ENHANCED_RST;
    phase       = WAIT_IDLE;
    frame_pid   = '0;
    byte_count  = '0;
    running_sum = '0;
    indicator   = 1'b0;
  endfunction

  // PID with both parity bits filled in for a six-bit identifier.
  static function logic [7:0] protect_id(logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // Eight-bit add with the carry folded back into bit zero.
  static function logic [7:0] fold_add(logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

  function int pending();
    return result_q.size();
  endfunction

  function void write_reg(logic [1:0] index, logic [5:0] data);
    case (index)
      lfr_pkg::REG_DATA_BYTES: data_bytes = data[3:0];
      lfr_pkg::REG_WATCH_ID:   watch_id   = data;
      lfr_pkg::REG_ENHANCED:   enhanced   = data[0];
      default: ;
    endcase
  endfunction

  // Advance the frame state by one accepted input transfer.
  function void note_input(logic cmd, logic [7:0] b);
    frame_result_t r;
    logic [3:0]    len;
    logic [7:0]    cs;
    if (cmd == lfr_pkg::CMD_BREAK) begin
      phase       = WAIT_SYNC;
      frame_pid   = '0;
      byte_count  = '0;
      running_sum = '0;
      return;
    end
    case (phase)
      WAIT_SYNC: phase = WAIT_PID;
      WAIT_PID: begin
        frame_pid = b;
        if (b != protect_id(b[5:0])) begin
          phase = WAIT_IDLE;
          r = '{lfr_pkg::ST_PARITY, b[5:0], 1'b0, 8'h00, indicator};
          result_q.push_back(r);
          parity_errs++;
        end else begin
          phase       = IN_DATA;
          byte_count  = '0;
          running_sum = enhanced ? b : 8'h00;
        end
      end
      IN_DATA: begin
        len = (data_bytes > lfr_pkg::MAX_DATA_BYTES) ? lfr_pkg::MAX_DATA_BYTES : data_bytes;
        if (byte_count < len) begin
          running_sum = fold_add(running_sum, b);
          byte_count  = byte_count + 4'd1;
        end else begin
          cs         = ~running_sum;
          r.frame_id = 6'(frame_pid & lfr_pkg::ID_MASK);
          r.status   = (cs == b) ? lfr_pkg::ST_OK : lfr_pkg::ST_CSUM;
          r.target_hit = (r.status == lfr_pkg::ST_OK) && (r.frame_id == watch_id);
          r.checksum = cs;
          indicator  = indicator ^ r.target_hit;
          r.led_on   = indicator;
          result_q.push_back(r);
          phase = WAIT_IDLE;
          if (r.status == lfr_pkg::ST_OK) ok_frames++;
          else csum_errs++;
          if (r.target_hit) target_hits++;
        end
      end
      default: phase = WAIT_IDLE;
    endcase
  endfunction

  task report(string msg);
    $display("[%0t] check failed: %s", $time, msg);
    errors++;
  endtask

  // Compare one result transfer with the oldest pending frame result.
  task check_result(logic [1:0] status, logic [5:0] frame_id, logic target_hit,
                    logic [7:0] checksum, logic led_on);
    frame_result_t want;
    if (result_q.size() == 0) begin
      report($sformatf("unexpected result status=%0d id=%0d", status, frame_id));
      return;
    end
    want = result_q.pop_front();
    if (status !== want.status)
      report($sformatf("status %0d, want %0d", status, want.status));
    if (frame_id !== want.frame_id)
      report($sformatf("frame_id %0d, want %0d", frame_id, want.frame_id));
    if (target_hit !== want.target_hit)
      report($sformatf("target_hit %0d, want %0d", target_hit, want.target_hit));
    if (checksum !== want.checksum)
      report($sformatf("checksum %02h, want %02h", checksum, want.checksum));
    if (led_on !== want.led_on)
      report($sformatf("led_on %0d, want %0d", led_on, want.led_on));
  endtask
endclass

module lin_frame_receiver_tb;
  localparam int         IDLE_PCT      = 32;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         STALL_LIMIT   = 4000;
  localparam int         PHASE_ITEMS   = 242;
  localparam logic [7:0] SYNC_BYTE     = 8'h55;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_command;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_status;
  logic [5:0] out_frame_id;
  logic       out_target_hit;
  logic [7:0] out_computed_checksum;
  logic       out_led_on;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [5:0] cfg_data;

  lin_scoreboard sb = new();

  int in_idle_pct  = IDLE_PCT;
  int out_idle_pct = IDLE_PCT;
  bit hold_req     = 1'b0;
  int frame_items  = 0;
  int settings     = 0;
  int stall_cycles = 0;

  lin_frame_receiver dut (.*);

  // Clock generation.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Transfer monitor: registers, inputs and results are all seen at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_input(in_command, in_rx_byte);
      if (out_valid && out_ready)
        sb.check_result(out_status, out_frame_id, out_target_hit,
                        out_computed_checksum, out_led_on);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results pending",
               STALL_LIMIT, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result receiver with random stalls and one long hold-off on request.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Offer one item and return at the falling edge after its transfer.
  task automatic send_item(logic cmd, logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Build one frame for the current settings; cut > 0 sends only its first items.
  task automatic send_frame(logic [5:0] id, bit bad_pid, bit bad_csum, int cut);
    logic [8:0] seq[$];
    logic [7:0] pid;
    logic [7:0] sum;
    logic [7:0] d;
    int         len;
    int         n;
    len = int'((sb.data_bytes > lfr_pkg::MAX_DATA_BYTES) ?
               lfr_pkg::MAX_DATA_BYTES : sb.data_bytes);
    seq.push_back({lfr_pkg::CMD_BREAK, 8'($urandom_range(255))});
    seq.push_back({lfr_pkg::CMD_BYTE,
                   ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : SYNC_BYTE});
    pid = sb.protect_id(id);
    if (bad_pid) pid ^= 8'(1 << $urandom_range(7));
    seq.push_back({lfr_pkg::CMD_BYTE, pid});
    sum = sb.enhanced ? pid : 8'h00;
    for (int i = 0; i < len; i++) begin
      // Bias toward all-zero and all-one bytes to work the carry fold.
      case ($urandom_range(7))
        0:       d = 8'h00;
        1:       d = 8'hFF;
        default: d = 8'($urandom_range(255));
      endcase
      sum = sb.fold_add(sum, d);
      seq.push_back({lfr_pkg::CMD_BYTE, d});
    end
    d = ~sum;
    if (bad_csum) d ^= 8'($urandom_range(1, 255));
    seq.push_back({lfr_pkg::CMD_BYTE, d});
    n = (cut > 0 && cut < seq.size()) ? cut : seq.size();
    for (int i = 0; i < n; i++) begin
      send_item(seq[i][8], seq[i][7:0]);
      frame_items++;
    end
  endtask

  // Write all three registers back to back.
  task automatic write_config(logic [3:0] len, logic [5:0] tgt, logic enh);
    logic [1:0] idx[3];
    logic [5:0] val[3];
    idx = '{lfr_pkg::REG_DATA_BYTES, lfr_pkg::REG_WATCH_ID, lfr_pkg::REG_ENHANCED};
    val[0] = {2'($urandom_range(3)), len};
    val[1] = tgt;
    val[2] = {5'($urandom_range(31)), enh};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Stop offering items until every pending result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mixed traffic: mostly well-formed frames, some broken ones and some noise.
  task automatic run_traffic(int n);
    int         goal;
    int         r;
    logic [5:0] id;
    goal = frame_items + n;
    while (frame_items < goal) begin
      r  = $urandom_range(99);
      id = ($urandom_range(2) == 0) ? sb.watch_id : 6'($urandom_range(63));
      if (r < 65)
        send_frame(id, $urandom_range(11) == 0, $urandom_range(7) == 0, 0);
      else if (r < 78)
        send_frame(id, 1'b0, 1'b0, $urandom_range(1, 11));
      else if (r < 88)
        send_frame(id, 1'b1, 1'b0, 0);
      else
        repeat ($urandom_range(1, 3))
          send_item($urandom_range(1) ? lfr_pkg::CMD_BYTE : lfr_pkg::CMD_BREAK,
                    8'($urandom_range(255)));
    end
  endtask

  // Main sequence.
  initial begin
    logic [3:0] len;
    logic [5:0] tgt;
    logic       enh;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_command = lfr_pkg::CMD_BREAK;
    in_rx_byte = 8'h00;
    cfg_valid  = 1'b0;
    cfg_index  = lfr_pkg::REG_DATA_BYTES;
    cfg_data   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a stray byte while idle, then a full frame at reset settings on the target.
    send_item(lfr_pkg::CMD_BYTE, 8'hFF);
    send_frame(lfr_pkg::WATCH_ID_RST, 1'b0, 1'b0, 0);
    drain_results();

    // Directed: empty data field, classic sum, top identifier as target.
    write_config(4'd0, 6'h3F, 1'b0);
    send_frame(6'h3F, 1'b0, 1'b0, 0);
    send_frame(6'h00, 1'b1, 1'b0, 3);
    // A break in the middle of a frame, then a bad checksum.
    send_frame(6'h15, 1'b0, 1'b0, 3);
    send_frame(6'h2A, 1'b0, 1'b1, 0);
    drain_results();

    // Random phases, each with its own settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin len = 4'hF; tgt = 6'h00; enh = 1'b1; end
        1: begin len = 4'd1; tgt = 6'h3F; enh = 1'b0; end
        2: begin len = 4'd8; tgt = 6'($urandom_range(63)); enh = 1'b1; end
        3: begin len = 4'd0; tgt = 6'($urandom_range(63)); enh = 1'($urandom_range(1)); end
        default: begin
          len = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
          tgt = 6'($urandom_range(63));
          enh = 1'($urandom_range(1));
        end
      endcase
      write_config(len, tgt, enh);
      if (ph == 1) begin
        // No idling on either side, and one long receiver hold-off to back up the input.
        in_idle_pct  = 0;
        out_idle_pct = 0;
        hold_req     = 1'b1;
      end
      if (ph == 3) begin
        run_traffic(PHASE_ITEMS / 2);
        drain_results();
        run_traffic(PHASE_ITEMS / 2);
      end else begin
        run_traffic(PHASE_ITEMS);
      end
      drain_results();
      in_idle_pct  = IDLE_PCT;
      out_idle_pct = IDLE_PCT;
    end

    $display("Run covered %0d good frames (%0d on target), %0d checksum and %0d parity errors",
             sb.ok_frames, sb.target_hits, sb.csum_errs, sb.parity_errs);
    $display("Frame items sent: %0d over %0d register settings", frame_items, settings);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
